/* hdl/cursor_linked_list_engine_core_defines.svh */
// Assertion macros for the cursor linked list engine.
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLL_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLL_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLL_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

/* hdl/cll_pkg.sv */
// ---------------------------------------------------------------------------
// cll_pkg
// Shared types and codes for the cursor linked list engine.
// ---------------------------------------------------------------------------
package cll_pkg;
	localparam logic [2:0] MODE_INS_FIRST = 3'd0;
	localparam logic [2:0] MODE_INS_END   = 3'd1;
	localparam logic [2:0] MODE_INS_POS   = 3'd2;
	localparam logic [2:0] MODE_DEL_VAL   = 3'd3;
	localparam logic [2:0] MODE_DEL_POS   = 3'd4;
	localparam logic [2:0] MODE_DEL_ALL   = 3'd5;
	localparam logic [2:0] MODE_CLEAR     = 3'd6;
	localparam logic [2:0] MODE_UNUSED    = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [7:0] value;
		logic [5:0]        position;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] removed_count;
		logic [5:0] list_length;
	} rsp_t;
endpackage

/* hdl/cll_cell.sv */
// ---------------------------------------------------------------------------
// cll_cell
// One list slot: holds a value and a valid bit; shifts with its neighbors.
// ---------------------------------------------------------------------------
module cll_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,     // take left neighbor (insert shift)
	input  logic             take_ins, // insert lands here
	input  logic             take_r,   // take right neighbor (compaction)
	input  logic             kill_all,
	input  logic [7:0]       ins_val,
	input  logic [7:0]       left_val,
	input  logic             left_vld,
	input  logic [7:0]       right_val,
	input  logic             right_vld,
	output logic [7:0]       val,
	output logic             vld
);
	logic [7:0] val_q;
	logic       vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (kill_all) begin
			vld_q <= 1'b0;
		end else if (take_ins) begin
			vld_q <= 1'b1;
		end else if (load) begin
			vld_q <= left_vld;
		end else if (take_r) begin
			vld_q <= right_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ins) begin
			val_q <= ins_val;
		end else if (load) begin
			val_q <= left_val;
		end else if (take_r) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;
	assign vld = vld_q;
endmodule

/* hdl/cursor_linked_list_engine_core.sv */
// ---------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Ordered list of byte values held as a row of shifting cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: mode, value,
//   position. rsp channel (rsp_valid/rsp_ready/rsp) returns one item per
//   request: status, removed_count, list_length.
//   The list lives in a row of CELLS cells, element k in cell k. Inserts
//   shift the tail right by one cell as they are accepted; deletes compact
//   the row one cell per cycle, walking the hole toward the tail.
//   Inserts, clear and rejected requests go from accept straight to the
//   response state. Positional delete at p compacts from cell p to the
//   tail. Delete by value scans up to the match and compacts from there.
//   Delete-all scans the row once and compacts once per match, resuming
//   the scan at the freed cell.
//   One item is in flight at a time; req_ready is high while the engine
//   is idle. Reset empties the list at once (all valid bits cleared).
//   A stalled response holds in its register; the engine may take and
//   finish one more item, then waits until the register frees.
// ---------------------------------------------------------------------------
`include "cursor_linked_list_engine_core_defines.svh"
module cursor_linked_list_engine_core #(
	parameter int CELLS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cll_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cll_pkg::rsp_t  rsp
);
	localparam int IW = $clog2(CELLS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMPACT, S_DONE} state_t;

	state_t          state_q;
	cll_pkg::req_t   req_q;
	logic [IW-1:0]   len_q;
	logic [IW-1:0]   rm_q;
	logic [IW-1:0]   ptr_q;     // compaction / scan index
	logic [IW-1:0]   base_q;    // where the scan resumes after a compaction
	logic            found_q;
	logic [1:0]      st_q;
	logic            rsp_vld_q;
	cll_pkg::rsp_t   rsp_q;

	logic [7:0]       cval [CELLS];
	logic [CELLS-1:0] cvld;
	logic [CELLS-1:0] c_ins, c_load, c_taker;
	logic             kill_all;
	logic             start;
	logic [IW-1:0]    ipos;
	logic             do_ins;
	logic [IW-1:0]    ptr_idx;

	assign start     = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// insertion point and legality, decided at accept
	always_comb begin
		ipos   = '0;
		do_ins = 1'b0;
		case (req.mode)
			cll_pkg::MODE_INS_FIRST: begin
				ipos   = '0;
				do_ins = (len_q != IW'(CELLS));
			end
			cll_pkg::MODE_INS_END: begin
				ipos   = len_q;
				do_ins = (len_q != IW'(CELLS));
			end
			cll_pkg::MODE_INS_POS: begin
				ipos   = IW'(req.position);
				do_ins = (len_q != IW'(CELLS)) && ({1'b0, req.position} <= 7'(len_q));
			end
			default: begin
				ipos   = '0;
				do_ins = 1'b0;
			end
		endcase
		do_ins = do_ins && start;
	end

	assign kill_all = start && (req.mode == cll_pkg::MODE_CLEAR);
	assign ptr_idx  = ptr_q;

	// compaction: only the cell at ptr takes its right neighbor, so each
	// cycle the hole moves one step right
	genvar g;
	generate
		for (g = 0; g < CELLS; g++) begin : g_row
			logic [7:0] lv, rv;
			logic       lvl, rvl;
			if (g == 0) begin : g_l0
				assign lv = 8'd0; assign lvl = 1'b0;
			end else begin : g_ln
				assign lv = cval[g-1]; assign lvl = cvld[g-1];
			end
			if (g == CELLS - 1) begin : g_rl
				assign rv = 8'd0; assign rvl = 1'b0;
			end else begin : g_rn
				assign rv = cval[g+1]; assign rvl = cvld[g+1];
			end
			assign c_ins[g]   = do_ins && (IW'(g) == ipos);
			assign c_load[g]  = do_ins && (IW'(g) > ipos);
			assign c_taker[g] = (state_q == S_COMPACT) && (IW'(g) == ptr_idx);
			cll_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.load(c_load[g]), .take_ins(c_ins[g]), .take_r(c_taker[g]),
				.kill_all(kill_all), .ins_val(req.value),
				.left_val(lv), .left_vld(lvl), .right_val(rv), .right_vld(rvl),
				.val(cval[g]), .vld(cvld[g])
			);
		end
	endgenerate

	// scan read of one cell per cycle, paused while a match is compacted
	logic [7:0] scan_val;
	logic       scan_vld;
	always_comb begin
		scan_val = 8'd0;
		scan_vld = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			if (IW'(k) == ptr_q) begin
				scan_val = cval[k];
				scan_vld = cvld[k];
			end
		end
	end

	// hole at ptr_q moves right: cell ptr takes ptr+1 each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= '0;
			len_q     <= '0;
			rm_q      <= '0;
			ptr_q     <= '0;
			base_q    <= '0;
			found_q   <= 1'b0;
			st_q      <= cll_pkg::ST_OK;
			rsp_vld_q <= 1'b0;
			rsp_q     <= '0;
		end else begin
			if (rsp_vld_q && rsp_ready && state_q != S_DONE) rsp_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						rm_q    <= '0;
						ptr_q   <= '0;
						base_q  <= '0;
						found_q <= 1'b0;
						st_q    <= cll_pkg::ST_OK;
						state_q <= S_DONE;
						case (req.mode)
							cll_pkg::MODE_INS_FIRST, cll_pkg::MODE_INS_END,
							cll_pkg::MODE_INS_POS: begin
								if (len_q == IW'(CELLS)) st_q <= cll_pkg::ST_FULL;
								else if (!do_ins) st_q <= cll_pkg::ST_NOTFOUND;
								else len_q <= len_q + 1'b1;
							end
							cll_pkg::MODE_DEL_VAL, cll_pkg::MODE_DEL_ALL: begin
								state_q <= S_SCAN;
							end
							cll_pkg::MODE_DEL_POS: begin
								if ({1'b0, req.position} >= 7'(len_q)) begin
									st_q <= cll_pkg::ST_NOTFOUND;
								end else begin
									ptr_q   <= IW'(req.position);
									rm_q    <= IW'(1);
									len_q   <= len_q - 1'b1;
									state_q <= S_COMPACT;
								end
							end
							cll_pkg::MODE_CLEAR: begin
								rm_q  <= len_q;
								len_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (!scan_vld || ptr_q == IW'(CELLS - 1) && !(scan_val == req_q.value)) begin
						if (req_q.mode == cll_pkg::MODE_DEL_VAL && !found_q)
							st_q <= cll_pkg::ST_NOTFOUND;
						state_q <= S_DONE;
					end else if (scan_val == req_q.value) begin
						found_q <= 1'b1;
						rm_q    <= rm_q + 1'b1;
						len_q   <= len_q - 1'b1;
						base_q  <= ptr_q;
						state_q <= S_COMPACT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_COMPACT: begin
					// retain ptr start for rescan; walk hole to tail
					if (ptr_q == IW'(CELLS - 1) || !cvld[ptr_q + 1'b1 >= IW'(CELLS) ?
						'0 : ptr_q[$clog2(CELLS)-1:0] + 1'b1]) begin
						if (req_q.mode == cll_pkg::MODE_DEL_ALL) begin
							ptr_q   <= base_q;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!rsp_vld_q || rsp_ready) begin
						rsp_q.status        <= st_q;
						rsp_q.removed_count <= 6'(rm_q);
						rsp_q.list_length   <= 6'(len_q);
						rsp_vld_q           <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CLL_ASSERT(a_len_bound, clk, arst_n, len_q <= IW'(CELLS), "length beyond pool")
	`CLL_ASSERT(a_no_accept_busy, clk, arst_n, start |-> state_q == S_IDLE, "accept while busy")
	`CLL_ASSERT(a_rsp_after_done, clk, arst_n, $rose(rsp_vld_q) |-> $past(state_q) == S_DONE, "response not from done")
	`CLL_ASSERT(a_vld_count, clk, arst_n, (state_q == S_IDLE) |-> $countones(cvld) == int'(len_q), "valid bits disagree with length")
endmodule
